@@ hw/rtl/tri_ang_pkg.sv @@
// Shared constants, types and helpers of the triangulation angle unit.
// No dependencies; imported by tri_ang_isqrt, tri_ang_cordic, the top level and the testbench.
`default_nettype none

package tri_ang_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANGLE_W         = 17;
  localparam int SQRT_BITS       = 31;
  localparam int CORDIC_STEPS    = 31;
  localparam int CORDIC_XW       = 34;
  localparam int CORDIC_ZW       = 33;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
    30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
    30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
    30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1
  };

  // Sideband that rides along the square root pipeline.
  typedef struct packed {
    logic        deg;
    logic [29:0] dot;
  } sqrt_side_t;

  // Least right shift that brings a magnitude below 2^30.
  function automatic logic [5:0] fit_shift(input logic [62:0] m);
    logic [5:0] len;
    len = 6'd0;
    for (int j = 0; j < 63; j++) begin
      if (m[j]) len = 6'(j + 1);
    end
    return (len > 6'd30) ? len - 6'd30 : 6'd0;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tri_ang_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on tri_ang_pkg.
`default_nettype none

module tri_ang_isqrt (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  wire [63:0]               rad_i,
  input  wire tri_ang_pkg::sqrt_side_t side_i,
  output logic                     valid_o,
  output logic [30:0]              root_o,
  output tri_ang_pkg::sqrt_side_t  side_o
);
  import tri_ang_pkg::*;

  logic        vld_q  [SQRT_BITS];
  logic [63:0] rem_q  [SQRT_BITS];
  logic [30:0] root_q [SQRT_BITS];
  sqrt_side_t  side_q [SQRT_BITS];

  for (genvar g = 0; g < SQRT_BITS; g++) begin : g_bit
    logic        vld_in;
    logic [63:0] rem_in;
    logic [30:0] root_in;
    sqrt_side_t  side_in;
    logic [63:0] trial;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    // candidate bit b = SQRT_BITS-1-g: (r + 2^b)^2 - r^2
    assign trial = ({33'd0, root_in} << (SQRT_BITS - g)) +
                   (64'd1 << (2 * (SQRT_BITS - 1 - g)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        if (rem_in >= trial) begin
          rem_q[g]  <= rem_in - trial;
          root_q[g] <= root_in | (31'd1 << (SQRT_BITS - 1 - g));
        end else begin
          rem_q[g]  <= rem_in;
          root_q[g] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[SQRT_BITS-1];
  assign root_o  = root_q[SQRT_BITS-1];
  assign side_o  = side_q[SQRT_BITS-1];

endmodule

`default_nettype wire

@@ hw/rtl/tri_ang_cordic.sv @@
// Pipelined CORDIC in vectoring mode, one rotation per stage.
// Depends on tri_ang_pkg.
`default_nettype none

module tri_ang_cordic (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      en_i,
  input  wire                                      valid_i,
  input  wire [29:0]                               x_i,
  input  wire [30:0]                               y_i,
  input  wire                                      deg_i,
  output logic                                     valid_o,
  output logic signed [tri_ang_pkg::CORDIC_ZW-1:0] z_o,
  output logic                                     deg_o
);
  import tri_ang_pkg::*;

  logic                        vld_q [CORDIC_STEPS];
  logic                        deg_q [CORDIC_STEPS];
  logic signed [CORDIC_XW-1:0] x_q   [CORDIC_STEPS];
  logic signed [CORDIC_XW-1:0] y_q   [CORDIC_STEPS];
  logic signed [CORDIC_ZW-1:0] z_q   [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    logic                        vld_in;
    logic                        deg_in;
    logic signed [CORDIC_XW-1:0] x_in;
    logic signed [CORDIC_XW-1:0] y_in;
    logic signed [CORDIC_ZW-1:0] z_in;
    logic signed [CORDIC_XW-1:0] xs;
    logic signed [CORDIC_XW-1:0] ys;
    logic signed [CORDIC_ZW-1:0] ang;

    if (g == 0) begin : g_first
      assign vld_in = valid_i;
      assign deg_in = deg_i;
      assign x_in   = CORDIC_XW'($signed({1'b0, x_i}));
      assign y_in   = CORDIC_XW'($signed({1'b0, y_i}));
      assign z_in   = '0;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign deg_in = deg_q[g-1];
      assign x_in   = x_q[g-1];
      assign y_in   = y_q[g-1];
      assign z_in   = z_q[g-1];
    end

    assign xs  = x_in >>> g;
    assign ys  = y_in >>> g;
    assign ang = CORDIC_ZW'($signed({1'b0, ATAN_Q30[g]}));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        deg_q[g] <= deg_in;
        if (!y_in[CORDIC_XW-1]) begin
          x_q[g] <= x_in + ys;
          y_q[g] <= y_in - xs;
          z_q[g] <= z_in + ang;
        end else begin
          x_q[g] <= x_in - ys;
          y_q[g] <= y_in + xs;
          z_q[g] <= z_in - ang;
        end
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STEPS-1];
  assign z_o     = z_q[CORDIC_STEPS-1];
  assign deg_o   = deg_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/triangulation_angle_unit.sv @@
// Top level of the triangulation angle unit: ray setup, cross/dot products,
// scaling, square root and CORDIC pipelines. Depends on tri_ang_pkg,
// tri_ang_isqrt and tri_ang_cordic.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | slave     | in_valid_i / in_stall_o | cam1_*, cam2_*, point_* (s32)
//   out     | master    | out_valid_o/out_stall_i | ray_angle_o (u17, Q.16 rad)
//
// One request enters per cycle while the output does not stall; each result passes
// through 9 setup stages, 31 square root stages, 31 CORDIC stages and 1 output
// stage. The square root and CORDIC chains, one bit or one rotation per stage,
// make up most of that depth.
// Reset clears all valid bits; payload registers are not reset.
// A stall on the output freezes the whole pipeline, so in_stall_o rises exactly
// when a result is held and not taken; nothing is dropped or repeated.
`default_nettype none

module triangulation_angle_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire signed [31:0]  cam1_x_i,
  input  wire signed [31:0]  cam1_y_i,
  input  wire signed [31:0]  cam1_z_i,
  input  wire signed [31:0]  cam2_x_i,
  input  wire signed [31:0]  cam2_y_i,
  input  wire signed [31:0]  cam2_z_i,
  input  wire signed [31:0]  point_x_i,
  input  wire signed [31:0]  point_y_i,
  input  wire signed [31:0]  point_z_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [16:0]        ray_angle_o
);
  import tri_ang_pkg::*;

  localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;

  // advance every stage unless a finished result is held
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: ray components a = P - C1, b = P - C2
  logic signed [31:0] pt [3];
  logic signed [31:0] c1 [3];
  logic signed [31:0] c2 [3];
  logic signed [32:0] ra_d [3];
  logic signed [32:0] rb_d [3];
  logic               deg_d;

  assign pt = '{point_x_i, point_y_i, point_z_i};
  assign c1 = '{cam1_x_i, cam1_y_i, cam1_z_i};
  assign c2 = '{cam2_x_i, cam2_y_i, cam2_z_i};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ra_d[j] = {pt[j][31], pt[j]} - {c1[j][31], c1[j]};
      rb_d[j] = {pt[j][31], pt[j]} - {c2[j][31], c2[j]};
    end
    // a zero-length ray forces a zero angle
    deg_d = ((ra_d[0] == '0) && (ra_d[1] == '0) && (ra_d[2] == '0)) ||
            ((rb_d[0] == '0) && (rb_d[1] == '0) && (rb_d[2] == '0));
  end

  logic               v1_q, deg1_q;
  logic signed [32:0] ra_q [3];
  logic signed [32:0] rb_q [3];

  // ---------------- stage 2: scale each ray below 2^30
  logic [32:0]        ma [3];
  logic [32:0]        mb [3];
  logic [32:0]        ora, orb;
  logic [5:0]         ka, kb;
  logic [32:0]        sha [3];
  logic [32:0]        shb [3];
  logic signed [30:0] sa_d [3];
  logic signed [30:0] sb_d [3];

  always_comb begin
    ora = '0;
    orb = '0;
    for (int j = 0; j < 3; j++) begin
      ma[j] = ra_q[j][32] ? 33'(-ra_q[j]) : 33'(ra_q[j]);
      mb[j] = rb_q[j][32] ? 33'(-rb_q[j]) : 33'(rb_q[j]);
      ora   = ora | ma[j];
      orb   = orb | mb[j];
    end
    // the OR has the bit length of the largest magnitude
    ka = fit_shift({30'd0, ora});
    kb = fit_shift({30'd0, orb});
    for (int j = 0; j < 3; j++) begin
      sha[j]  = ma[j] >> ka;
      shb[j]  = mb[j] >> kb;
      sa_d[j] = ra_q[j][32] ? -$signed({1'b0, sha[j][29:0]}) : $signed({1'b0, sha[j][29:0]});
      sb_d[j] = rb_q[j][32] ? -$signed({1'b0, shb[j][29:0]}) : $signed({1'b0, shb[j][29:0]});
    end
  end

  logic               v2_q, deg2_q;
  logic signed [30:0] sa_q [3];
  logic signed [30:0] sb_q [3];

  // ---------------- stage 3: the nine products
  logic               v3_q, deg3_q;
  logic signed [61:0] pc_q [6];   // cross-product terms
  logic signed [61:0] pd_q [3];   // dot-product terms

  // ---------------- stage 4: cross and dot
  logic               v4_q, deg4_q;
  logic signed [62:0] cr_q [3];
  logic signed [63:0] dt_q;

  // ---------------- stage 5: magnitudes
  logic               v5_q, deg5_q;
  logic [62:0]        mc_q [3];
  logic [62:0]        md_q;

  // ---------------- stage 6: common shift
  logic               v6_q, deg6_q;
  logic [62:0]        mc6_q [3];
  logic [62:0]        md6_q;
  logic [5:0]         k6_q;

  // ---------------- stage 7: shifted to 30 bits
  logic               v7_q, deg7_q;
  logic [29:0]        c7_q [3];
  logic [29:0]        d7_q;

  // ---------------- stage 8: squares
  logic               v8_q, deg8_q;
  logic [59:0]        sq_q [3];
  logic [29:0]        d8_q;

  // ---------------- stage 9: sum of squares
  logic               v9_q;
  logic [63:0]        s2_q;
  sqrt_side_t         side9_q;

  logic [62:0] or_mag;
  assign or_mag = mc_q[0] | mc_q[1] | mc_q[2] | md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deg1_q <= deg_d;
      ra_q   <= ra_d;
      rb_q   <= rb_d;

      deg2_q <= deg1_q;
      sa_q   <= sa_d;
      sb_q   <= sb_d;

      deg3_q   <= deg2_q;
      pc_q[0]  <= sa_q[1] * sb_q[2];
      pc_q[1]  <= sa_q[2] * sb_q[1];
      pc_q[2]  <= sa_q[2] * sb_q[0];
      pc_q[3]  <= sa_q[0] * sb_q[2];
      pc_q[4]  <= sa_q[0] * sb_q[1];
      pc_q[5]  <= sa_q[1] * sb_q[0];
      pd_q[0]  <= sa_q[0] * sb_q[0];
      pd_q[1]  <= sa_q[1] * sb_q[1];
      pd_q[2]  <= sa_q[2] * sb_q[2];

      deg4_q   <= deg3_q;
      cr_q[0]  <= 63'(pc_q[0]) - 63'(pc_q[1]);
      cr_q[1]  <= 63'(pc_q[2]) - 63'(pc_q[3]);
      cr_q[2]  <= 63'(pc_q[4]) - 63'(pc_q[5]);
      dt_q     <= 64'(pd_q[0]) + 64'(pd_q[1]) + 64'(pd_q[2]);

      deg5_q <= deg4_q;
      for (int j = 0; j < 3; j++) begin
        mc_q[j] <= cr_q[j][62] ? 63'(-cr_q[j]) : 63'(cr_q[j]);
      end
      md_q <= dt_q[63] ? 63'(-dt_q) : 63'(dt_q);

      deg6_q <= deg5_q;
      mc6_q  <= mc_q;
      md6_q  <= md_q;
      k6_q   <= fit_shift(or_mag);

      deg7_q <= deg6_q;
      for (int j = 0; j < 3; j++) begin
        c7_q[j] <= 30'(mc6_q[j] >> k6_q);
      end
      d7_q <= 30'(md6_q >> k6_q);

      deg8_q <= deg7_q;
      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= c7_q[j] * c7_q[j];
      end
      d8_q <= d7_q;

      side9_q.deg <= deg8_q;
      side9_q.dot <= d8_q;
      s2_q        <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    end
  end

  // ---------------- |a x b| by square root
  logic       sq_vld;
  logic [30:0] sq_root;
  sqrt_side_t sq_side;

  tri_ang_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .rad_i   (s2_q),
    .side_i  (side9_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------- atan2(|a x b|, |a.b|)
  logic                        co_vld;
  logic signed [CORDIC_ZW-1:0] co_z;
  logic                        co_deg;

  tri_ang_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_vld),
    .x_i     (sq_side.dot),
    .y_i     (sq_root),
    .deg_i   (sq_side.deg),
    .valid_o (co_vld),
    .z_o     (co_z),
    .deg_o   (co_deg)
  );

  // ---------------- clamp to [0, pi/2], round half up, output register
  logic [30:0] z_clamp;
  logic [31:0] z_round;

  always_comb begin
    if (co_z[CORDIC_ZW-1]) begin
      z_clamp = '0;
    end else if (co_z[CORDIC_ZW-2:0] > {1'b0, HALF_PI_Q30}) begin
      z_clamp = HALF_PI_Q30;
    end else begin
      z_clamp = co_z[30:0];
    end
    z_round = ({1'b0, z_clamp} + (32'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
  end

  logic        out_valid_q;
  logic [16:0] ray_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= co_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_angle_q <= co_deg ? '0 : z_round[ANGLE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign ray_angle_o = ray_angle_q;

endmodule

`default_nettype wire

@@ hw/rtl/tri_ang_checker.sv @@
// Port-level checks of the triangulation angle unit, bound to the top level.
// Depends on triangulation_angle_unit's port list only.
`default_nettype none

module tri_ang_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [16:0] ray_angle_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ray_angle_o))
    else $error("stalled result changed");

  // the folded angle never exceeds pi/2
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ray_angle_o <= 17'd102944)
    else $error("angle above pi/2");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // when the stall on a valid result falls, the input is not stalled in that cycle
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_stall_i) && out_valid_o |-> !in_stall_o)
    else $error("input stall outlived output stall");

endmodule

bind triangulation_angle_unit tri_ang_checker u_tri_ang_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ray_angle_o (ray_angle_o)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench of triangulation_angle_unit: directed and random requests, checked
// against a bit-exact predictor of the folded ray angle. Depends on tri_ang_pkg and triangulation_angle_unit.
`timescale 1ns / 100ps

module testbench;
  import tri_ang_pkg::*;

  typedef struct {
    logic signed [31:0] cam1 [3];
    logic signed [31:0] cam2 [3];
    logic signed [31:0] pnt [3];
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [31:0] cam1_x = '0, cam1_y = '0, cam1_z = '0;
  logic signed [31:0] cam2_x = '0, cam2_y = '0, cam2_z = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  wire in_stall;
  wire out_valid;
  wire [ANGLE_W-1:0] ray_angle;

  logic [ANGLE_W-1:0] expected_angles [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 11;
  bit hold_off = 1'b0;

  longint atan_tab [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  triangulation_angle_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cam1_x_i    (cam1_x),
    .cam1_y_i    (cam1_y),
    .cam1_z_i    (cam1_z),
    .cam2_x_i    (cam2_x),
    .cam2_y_i    (cam2_y),
    .cam2_z_i    (cam2_z),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .point_z_i   (point_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .ray_angle_o (ray_angle)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor of the folded angle
  // --------------------------------------------------------------------------

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // least right shift that brings a magnitude below 2^30
  function automatic int unsigned shift_to_fit(longint unsigned m);
    int unsigned k;
    k = 0;
    while ((m >> k) >= 64'd1073741824) k++;
    return k;
  endfunction

  // shift the magnitude, keep the sign (truncate toward zero)
  function automatic longint shrink_toward_zero(longint v, int unsigned k);
    longint unsigned m;
    m = magnitude(v) >> k;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] predict_ray_angle(request_t r);
    longint a [3], b [3], c [3];
    longint x, y, z, xs, ys, dotp, rounded;
    longint unsigned m, d, s2, cm;
    int unsigned ka, kb, k;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(r.pnt[i]) - longint'(r.cam1[i]);
      b[i] = longint'(r.pnt[i]) - longint'(r.cam2[i]);
    end
    // zero-length ray gives angle zero
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0))
      return '0;
    m = magnitude(a[0]);
    if (magnitude(a[1]) > m) m = magnitude(a[1]);
    if (magnitude(a[2]) > m) m = magnitude(a[2]);
    ka = shift_to_fit(m);
    m = magnitude(b[0]);
    if (magnitude(b[1]) > m) m = magnitude(b[1]);
    if (magnitude(b[2]) > m) m = magnitude(b[2]);
    kb = shift_to_fit(m);
    for (int i = 0; i < 3; i++) begin
      a[i] = shrink_toward_zero(a[i], ka);
      b[i] = shrink_toward_zero(b[i], kb);
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    dotp = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    d = magnitude(dotp);
    m = d;
    for (int i = 0; i < 3; i++)
      if (magnitude(c[i]) > m) m = magnitude(c[i]);
    k = shift_to_fit(m);
    d = d >> k;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      cm = magnitude(c[i]) >> k;
      s2 += cm * cm;
    end
    // vectoring CORDIC on (|dot|, |cross|)
    x = longint'(d);
    y = longint'(int_sqrt(s2));
    z = 0;
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_tab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    rounded = (z + (64'sd1 << (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    return rounded[ANGLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request at the falling edge, hold it until taken, then record
  // its expected angle. Valid stays high for a back-to-back request.
  task automatic send_request(request_t r);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cam1_x <= r.cam1[0];  cam1_y <= r.cam1[1];  cam1_z <= r.cam1[2];
    cam2_x <= r.cam2[0];  cam2_y <= r.cam2[1];  cam2_z <= r.cam2[2];
    point_x <= r.pnt[0];  point_y <= r.pnt[1];  point_z <= r.pnt[2];
    do @(posedge clk_i); while (in_stall);
    expected_angles.push_back(predict_ray_angle(r));
  endtask

  // drop valid once the last request is taken
  task automatic end_requests();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  function automatic request_t make_request(longint c1x, longint c1y, longint c1z,
                                            longint c2x, longint c2y, longint c2z,
                                            longint px, longint py, longint pz);
    request_t r;
    r.cam1[0] = c1x[31:0]; r.cam1[1] = c1y[31:0]; r.cam1[2] = c1z[31:0];
    r.cam2[0] = c2x[31:0]; r.cam2[1] = c2y[31:0]; r.cam2[2] = c2z[31:0];
    r.pnt[0]  = px[31:0];  r.pnt[1]  = py[31:0];  r.pnt[2]  = pz[31:0];
    return r;
  endfunction

  // Mostly realistic scenes: cameras and point within a random span around a
  // random center, sometimes a degenerate or fully random request.
  function automatic request_t random_request();
    request_t r;
    int unsigned kind, span;
    logic signed [31:0] base [3];
    kind = $urandom_range(99);
    span = 1 << $urandom_range(24, 1);
    for (int i = 0; i < 3; i++) base[i] = $urandom_range(32'h00FF_FFFF) - 32'sh0080_0000;
    for (int i = 0; i < 3; i++) begin
      if (kind < 20) begin
        r.cam1[i] = $urandom;
        r.cam2[i] = $urandom;
        r.pnt[i]  = $urandom;
      end else begin
        r.cam1[i] = base[i] + $signed($urandom_range(span)) - $signed(span / 2);
        r.cam2[i] = base[i] + $signed($urandom_range(span)) - $signed(span / 2);
        r.pnt[i]  = base[i] + $signed($urandom_range(span)) - $signed(span / 2);
      end
    end
    // zero-length ray on either side
    if (kind >= 90 && kind < 94) r.pnt = r.cam1;
    if (kind >= 94 && kind < 97) r.pnt = r.cam2;
    // parallel rays: second camera on the line through point and first camera
    if (kind >= 97) begin
      for (int i = 0; i < 3; i++) begin
        r.cam1[i] = r.pnt[i] + 32'(($urandom_range(64) - 32));
        r.cam2[i] = r.pnt[i] + 3 * (r.cam1[i] - r.pnt[i]);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // stall at random, or hold off completely while hold_off is set
  always @(negedge clk_i) begin
    out_stall <= hold_off || (idle_pct != 0 && $urandom_range(99) < idle_pct);
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    logic [ANGLE_W-1:0] want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ray_angle %0d",
                 $time, ray_angle);
        mismatch_count++;
      end else begin
        want = expected_angles.pop_front();
        if (ray_angle !== want) begin
          $display("%0t: ray_angle mismatch, expected %0d, actual %0d",
                   $time, want, ray_angle);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam longint ONE  = 64'sd65536;

  task automatic test_directed();
    // zero-length rays
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_request(5, 6, 7, 1, 1, 1, 5, 6, 7));
    send_request(make_request(1, 1, 1, -9, 4, 2, -9, 4, 2));
    // right angle and 45 degrees
    send_request(make_request(ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
    send_request(make_request(ONE, 0, 0, ONE, ONE, 0, 0, 0, 0));
    // parallel and antiparallel rays
    send_request(make_request(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0));
    send_request(make_request(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0));
    // near-zero and near-right angles
    send_request(make_request(0, 0, 100 * ONE, 1, 0, 100 * ONE, 0, 0, 0));
    send_request(make_request(ONE, 0, 0, 1, ONE, 0, 0, 0, 0));
    // coordinate extremes
    send_request(make_request(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, 0));
    send_request(make_request(MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV));
    send_request(make_request(MAXV, MINV, 0, MINV, MAXV, 0, MINV, MINV, MINV));
    send_request(make_request(MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV));
    send_request(make_request(MAXV, 0, 0, 0, MAXV, 0, MINV, MINV, MINV));
    send_request(make_request(-1, -1, -1, 1, -1, 1, 0, 0, 0));
    send_request(make_request(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_request(make_request(MINV, 0, 0, MAXV, 0, 0, MINV, 0, 0));
    send_request(make_request(-ONE, 3, 0, ONE, 4, 0, 0, 3, 0));
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // run back to back with no idling on either side
  task automatic test_full_rate(int unsigned count);
    int unsigned saved;
    saved = idle_pct;
    idle_pct = 0;
    repeat (count) send_request(random_request());
    idle_pct = saved;
  endtask

  // hold off the result side long enough for the pipeline to fill and stall
  task automatic test_backpressure(int unsigned count);
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (count) send_request(random_request());
    join
  endtask

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(250);
    test_full_rate(150);
    test_backpressure(150);
    test_random(50);
    end_requests();

    // drain, then allow the pipeline latency for stray results
    waited = 0;
    while (expected_angles.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("[triangulation_angle_unit] OK");
    end else begin
      $display("[triangulation_angle_unit] ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("[triangulation_angle_unit] ERROR");
    $finish;
  end

endmodule
